// ----- hw/rtl/mtg_pkg.sv -----
`default_nettype none

package mtg_pkg;

   // Store geometry.
   localparam int unsigned WORDS = 624;
   localparam int unsigned IDX_W = 10;

   localparam logic [IDX_W-1:0] WORDS_IDX  = IDX_W'(WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(WORDS - 1);
   localparam logic [IDX_W-1:0] SHIFT_M    = IDX_W'(397);
   localparam logic [IDX_W-1:0] FIRST_RUN  = IDX_W'(227);

   // Recurrence and tempering constants.
   localparam logic [31:0] MUL_LINEAR = 32'd1812433253;
   localparam logic [31:0] MUL_KEY_A  = 32'd1664525;
   localparam logic [31:0] MUL_KEY_B  = 32'd1566083941;
   localparam logic [31:0] KEY_SEED   = 32'd19650218;
   localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
   localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C   = 32'hefc60000;
   localparam logic [31:0] UPPER_MASK = 32'h80000000;
   localparam logic [31:0] LOWER_MASK = 32'h7fffffff;

   // Action codes of the request channel.
   typedef enum logic [1:0] {
      ACT_SEED_LINEAR = 2'd0,
      ACT_SEED_KEY    = 2'd1,
      ACT_NEXT        = 2'd2,
      ACT_NONE        = 2'd3
   } action_type;

   // Control from the sequencer to the state store.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [31:0]      wr_data;
      logic             rd_a_en;
      logic [IDX_W-1:0] rd_a_addr;
      logic             rd_b_en;
      logic [IDX_W-1:0] rd_b_addr;
   } store_ctrl_type;

   // Word mix used by both seeding recurrences.
   function automatic logic [31:0] mix(input logic [31:0] p);
      return p ^ (p >> 30);
   endfunction

   // One twist step from the upper, lower and far words.
   function automatic logic [31:0] twist_one(input logic [31:0] upper,
                                             input logic [31:0] lower,
                                             input logic [31:0] far_word);
      logic [31:0] y;
      logic [31:0] r;
      y = (upper & UPPER_MASK) | (lower & LOWER_MASK);
      r = far_word ^ (y >> 1);
      if (y[0]) begin
         r = r ^ MATRIX_A;
      end
      return r;
   endfunction

   // Output tempering.
   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mtg_store.sv -----
`default_nettype none

module mtg_store (
   input  wire logic                   clock,
   input  wire mtg_pkg::store_ctrl_type ctrl,
   output logic [31:0]                 rd_a_data,
   output logic [31:0]                 rd_b_data
);

   logic [31:0] mem [0:mtg_pkg::WORDS-1];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_a_en) begin
         rd_a_ff <= mem[ctrl.rd_a_addr];
      end
      if (ctrl.rd_b_en) begin
         rd_b_ff <= mem[ctrl.rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mt19937_generator_core.sv -----
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_action[1:0], req_seed_word[31:0]
// rsp       out        rsp_valid/rsp_stall  rsp_random_word[31:0]
//
// Seeding by recurrence computes each word through the shared multiplier (ST_LIN_MUL, ST_LIN_WR).
// Seeding by key runs the recurrence and then two mixing passes over the words,
// each word needing a store read and a multiply before its write.
// A next-word request reads and tempers one word, and runs the twist first on every 624th
// word; the twist reads each word through the store's two read ports.
// Reset is synchronous; the store contents are undefined until the first seeding.
// req_stall is high while an item is being worked on; a result waits in its output register.

module mt19937_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_seed_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_random_word
);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_LIN_FIRST = 13'b0000000000010,
      ST_LIN_MUL   = 13'b0000000000100,
      ST_LIN_WR    = 13'b0000000001000,
      ST_KEY_RD    = 13'b0000000010000,
      ST_KEY_WR    = 13'b0000000100000,
      ST_KEY_WRAP  = 13'b0000001000000,
      ST_KEY_TOP   = 13'b0000010000000,
      ST_TW_PRE    = 13'b0000100000000,
      ST_TW_RD     = 13'b0001000000000,
      ST_TW_WR     = 13'b0010000000000,
      ST_OUT_RD    = 13'b0100000000000,
      ST_OUT_TEMP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [mtg_pkg::IDX_W-1:0] i_ff, i_in;
   logic [mtg_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic [mtg_pkg::IDX_W-1:0] index_ff, index_in;
   logic                      pass_ff, pass_in;
   logic                      key_mode_ff, key_mode_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               key_ff, key_in;
   logic [31:0]               prev_ff, prev_in;
   logic [31:0]               prod_ff, prod_in;
   logic [31:0]               upper_ff, upper_in;
   logic [31:0]               rsp_word_ff, rsp_word_in;

   mtg_pkg::store_ctrl_type   store_ctrl;
   logic [31:0]               rd_a_data;
   logic [31:0]               rd_b_data;

   logic                      req_accept;
   logic [31:0]               mul_const;
   logic [31:0]               i_ext;
   logic [31:0]               key_mixed;
   logic [31:0]               add_b;
   logic [31:0]               key_sum;
   logic                      out_free;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign i_ext      = {{(32 - mtg_pkg::IDX_W){1'b0}}, i_ff};
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Shared multiplier: constant depends on the recurrence being run.
   always_comb begin
      if (state_ff == ST_LIN_MUL) begin
         mul_const = mtg_pkg::MUL_LINEAR;
      end else if (pass_ff) begin
         mul_const = mtg_pkg::MUL_KEY_B;
      end else begin
         mul_const = mtg_pkg::MUL_KEY_A;
      end
   end

   assign prod_in = mtg_pkg::mix(prev_ff) * mul_const;

   // Key mixing adder: adds the key in the first pass, subtracts the index in the second.
   assign key_mixed = rd_a_data ^ prod_ff;
   assign add_b     = pass_ff ? ~i_ext : key_ff;
   assign key_sum   = key_mixed + add_b + {31'd0, pass_ff};

   // Sequencer and store control.
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      cnt_in      = cnt_ff;
      index_in    = index_ff;
      pass_in     = pass_ff;
      key_mode_in = key_mode_ff;
      key_in      = key_ff;
      prev_in     = prev_ff;
      upper_in    = upper_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      store_ctrl           = '0;
      store_ctrl.rd_a_addr = i_ff;
      store_ctrl.rd_b_addr = i_ff;
      store_ctrl.wr_addr   = i_ff;
      store_ctrl.wr_data   = prev_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               i_in = '0;
               unique case (mtg_pkg::action_type'(req_action))
                  mtg_pkg::ACT_SEED_LINEAR: begin
                     key_mode_in = 1'b0;
                     prev_in     = req_seed_word;
                     state_in    = ST_LIN_FIRST;
                  end
                  mtg_pkg::ACT_SEED_KEY: begin
                     key_mode_in = 1'b1;
                     key_in      = req_seed_word;
                     prev_in     = mtg_pkg::KEY_SEED;
                     state_in    = ST_LIN_FIRST;
                  end
                  mtg_pkg::ACT_NEXT: begin
                     if (index_ff >= mtg_pkg::WORDS_IDX) begin
                        state_in = ST_TW_PRE;
                     end else begin
                        state_in = ST_OUT_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Linear recurrence: word 0 is the seed, each later word comes from the one before.
         ST_LIN_FIRST: begin
            store_ctrl.wr_en = 1'b1;
            i_in             = 10'(i_ff + 10'd1);
            state_in         = ST_LIN_MUL;
         end
         ST_LIN_MUL: begin
            state_in = ST_LIN_WR;
         end
         ST_LIN_WR: begin
            store_ctrl.wr_en   = 1'b1;
            store_ctrl.wr_data = prod_ff + i_ext;
            prev_in            = prod_ff + i_ext;
            if (i_ff == mtg_pkg::LAST_IDX) begin
               index_in = mtg_pkg::WORDS_IDX;
               if (key_mode_ff) begin
                  prev_in  = mtg_pkg::KEY_SEED;
                  i_in     = 10'd1;
                  cnt_in   = mtg_pkg::WORDS_IDX;
                  pass_in  = 1'b0;
                  state_in = ST_KEY_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               i_in     = 10'(i_ff + 10'd1);
               state_in = ST_LIN_MUL;
            end
         end

         // Key mixing passes: read the word, multiply the previous one, combine and write.
         ST_KEY_RD: begin
            store_ctrl.rd_a_en = 1'b1;
            state_in           = ST_KEY_WR;
         end
         ST_KEY_WR: begin
            store_ctrl.wr_en   = 1'b1;
            store_ctrl.wr_data = key_sum;
            prev_in            = key_sum;
            cnt_in             = 10'(cnt_ff - 10'd1);
            if (i_ff == mtg_pkg::LAST_IDX) begin
               state_in = ST_KEY_WRAP;
            end else begin
               i_in = 10'(i_ff + 10'd1);
               if (cnt_ff == 10'd1) begin
                  if (pass_ff) begin
                     state_in = ST_KEY_TOP;
                  end else begin
                     pass_in  = 1'b1;
                     cnt_in   = mtg_pkg::LAST_IDX;
                     state_in = ST_KEY_RD;
                  end
               end else begin
                  state_in = ST_KEY_RD;
               end
            end
         end
         ST_KEY_WRAP: begin
            // Word 0 takes a copy of the last word and the walk restarts at word 1.
            store_ctrl.wr_en   = 1'b1;
            store_ctrl.wr_addr = '0;
            i_in               = 10'd1;
            if (cnt_ff == '0) begin
               if (pass_ff) begin
                  state_in = ST_KEY_TOP;
               end else begin
                  pass_in  = 1'b1;
                  cnt_in   = mtg_pkg::LAST_IDX;
                  state_in = ST_KEY_RD;
               end
            end else begin
               state_in = ST_KEY_RD;
            end
         end
         ST_KEY_TOP: begin
            store_ctrl.wr_en   = 1'b1;
            store_ctrl.wr_addr = '0;
            store_ctrl.wr_data = mtg_pkg::UPPER_MASK;
            index_in           = mtg_pkg::WORDS_IDX;
            state_in           = ST_IDLE;
         end

         // Twist in place: the upper word is the lower word read one step earlier.
         ST_TW_PRE: begin
            store_ctrl.rd_a_en   = 1'b1;
            store_ctrl.rd_a_addr = '0;
            state_in             = ST_TW_RD;
         end
         ST_TW_RD: begin
            upper_in           = rd_a_data;
            store_ctrl.rd_a_en = 1'b1;
            store_ctrl.rd_b_en = 1'b1;
            if (i_ff == mtg_pkg::LAST_IDX) begin
               store_ctrl.rd_a_addr = '0;
            end else begin
               store_ctrl.rd_a_addr = 10'(i_ff + 10'd1);
            end
            if (i_ff < mtg_pkg::FIRST_RUN) begin
               store_ctrl.rd_b_addr = 10'(i_ff + mtg_pkg::SHIFT_M);
            end else begin
               store_ctrl.rd_b_addr = 10'(i_ff - mtg_pkg::FIRST_RUN);
            end
            state_in = ST_TW_WR;
         end
         ST_TW_WR: begin
            store_ctrl.wr_en   = 1'b1;
            store_ctrl.wr_data = mtg_pkg::twist_one(upper_ff, rd_a_data, rd_b_data);
            if (i_ff == mtg_pkg::LAST_IDX) begin
               index_in = '0;
               state_in = ST_OUT_RD;
            end else begin
               i_in     = 10'(i_ff + 10'd1);
               state_in = ST_TW_RD;
            end
         end

         // Read the word at the read index, temper it and hand it to the output register.
         ST_OUT_RD: begin
            store_ctrl.rd_a_en   = 1'b1;
            store_ctrl.rd_a_addr = index_ff;
            state_in             = ST_OUT_TEMP;
         end
         ST_OUT_TEMP: begin
            if (out_free) begin
               rsp_word_in  = mtg_pkg::temper(rd_a_data);
               rsp_valid_in = 1'b1;
               index_in     = 10'(index_ff + 10'd1);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         cnt_ff       <= '0;
         index_ff     <= mtg_pkg::WORDS_IDX;
         pass_ff      <= 1'b0;
         key_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         cnt_ff       <= cnt_in;
         index_ff     <= index_in;
         pass_ff      <= pass_in;
         key_mode_ff  <= key_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      prev_ff     <= prev_in;
      prod_ff     <= prod_in;
      upper_ff    <= upper_in;
      rsp_word_ff <= rsp_word_in;
   end

   mtg_store u_store (
      .clock     (clock),
      .ctrl      (store_ctrl),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mtg_checker.sv -----
`default_nettype none

module mtg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_action,
   input wire logic [31:0] req_seed_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_random_word
);

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   // A stalled result beat holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_random_word))
      else $error("result beat changed while stalled");

   // Seeding and next-word requests keep the block busy in the following cycle.
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_action == mtg_pkg::ACT_SEED_LINEAR ||
                   req_action == mtg_pkg::ACT_SEED_KEY ||
                   req_action == mtg_pkg::ACT_NEXT) |=> req_stall)
      else $error("block took a new beat right after a working request");

   // The unused action code leaves the block free.
   a_unused_action_free: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_action == mtg_pkg::ACT_NONE |=> !req_stall)
      else $error("unused action code made the block busy");

   // Seeding never produces a result beat.
   a_seed_no_result: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && (req_action == mtg_pkg::ACT_SEED_LINEAR ||
                                 req_action == mtg_pkg::ACT_SEED_KEY) |=> !rsp_valid)
      else $error("seeding produced a result beat");

   // A stalled request beat holds its action and seed word.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_action) && $stable(req_seed_word))
      else $error("request beat changed while stalled");

endmodule

bind mt19937_generator_core mtg_checker u_mtg_checker (.*);

`default_nettype wire
